// File: sv/hysteresis_lag_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hysteresis lag detector
// Clocked property wrappers used by the checks in the top-level module.
// ----------------------------------------------------------------------------
`ifndef HYSTERESIS_LAG_DETECTOR_TOP_MACROS_SVH
`define HYSTERESIS_LAG_DETECTOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define HLD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hysteresis lag detector: same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define HLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hysteresis lag detector: next-cycle check failed");

`endif

// File: sv/hld_pkg.sv
// ----------------------------------------------------------------------------
// Hysteresis lag detector package
// Widths, zone codes, sense codes and register indexes.
// ----------------------------------------------------------------------------
package hld_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int TIME_WIDTH     = 32;
  localparam int SENSE_WIDTH    = 2;
  localparam int CFG_DATA_WIDTH = (TIME_WIDTH > SAMPLE_WIDTH) ? TIME_WIDTH : SAMPLE_WIDTH;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [TIME_WIDTH-1:0]          time_t;

  typedef enum logic [1:0] {
    ZONE_BETWEEN = 2'd0,
    ZONE_LOW     = 2'd1,
    ZONE_HIGH    = 2'd2
  } zone_t;

  // Active sense codes; the unused code behaves as never active.
  localparam logic [SENSE_WIDTH-1:0] SENSE_HIGH  = 2'd0;
  localparam logic [SENSE_WIDTH-1:0] SENSE_LOW   = 2'd1;
  localparam logic [SENSE_WIDTH-1:0] SENSE_NEVER = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD_A  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD_B  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFF_DELAY    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ON_DELAY     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_SENSE = 3'd4;

  // Threshold pair as held in the configuration registers.
  typedef struct packed {
    sample_t a;
    sample_t b;
  } thresholds_t;

endpackage

// File: sv/hld_classify.sv
// ----------------------------------------------------------------------------
// Hysteresis lag detector zone classifier
// Orders the threshold pair and places a sample above, below or between.
// ----------------------------------------------------------------------------
module hld_classify (
  input  hld_pkg::thresholds_t thresholds,
  input  hld_pkg::sample_t     sample,
  output hld_pkg::zone_t       zone
);

  hld_pkg::sample_t lower;
  hld_pkg::sample_t upper;
  logic             a_smaller;

  assign a_smaller = thresholds.a < thresholds.b;
  assign lower     = a_smaller ? thresholds.a : thresholds.b;
  assign upper     = a_smaller ? thresholds.b : thresholds.a;

  always_comb begin
    priority if (sample > upper) begin
      zone = hld_pkg::ZONE_HIGH;
    end else if (sample < lower) begin
      zone = hld_pkg::ZONE_LOW;
    end else begin
      zone = hld_pkg::ZONE_BETWEEN;
    end
  end

endmodule

// File: sv/hysteresis_lag_detector_top.sv
// ----------------------------------------------------------------------------
// Hysteresis lag detector, top level
// Hysteresis comparator with on/off delay on a timestamped sample stream.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------
//  sample  | in        | sample_valid / sample_stall | sample, timestamp
//  result  | out       | result_valid / result_stall | latched_now, active, tracked_zone
//  cfg     | in        | cfg_we (always taken)       | cfg_index, cfg_data
//
//  One transaction in and one out per cycle when nothing stalls; a result is
//  offered once its sample has passed the input register and then the result register.
//  The rate is set by the combinational zone update between the two registers.
//  A stalled result holds; the input register keeps taking a transaction until it
//  is itself full behind that stall, then sample_stall rises.
//  Synchronous reset clears the configuration, the zone state and both valids.
//
`include "hysteresis_lag_detector_top_macros.svh"

module hysteresis_lag_detector_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [hld_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [hld_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  // sample channel
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  logic signed [hld_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [hld_pkg::TIME_WIDTH-1:0]        timestamp,
  // result channel
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic                                  latched_now,
  output logic                                  active,
  output logic [1:0]                            tracked_zone
);

  // Configuration registers
  hld_pkg::thresholds_t                 thresholds;
  hld_pkg::time_t                       off_delay;
  hld_pkg::time_t                       on_delay;
  logic [hld_pkg::SENSE_WIDTH-1:0]      active_sense;

  // Input register
  logic                                 s1_valid;
  hld_pkg::sample_t                     s1_sample;
  hld_pkg::time_t                       s1_timestamp;

  // Zone tracking state
  hld_pkg::zone_t                       zone;
  hld_pkg::zone_t                       latched_zone;
  logic                                 is_stable;
  hld_pkg::time_t                       zone_start_time;

  // Update logic
  hld_pkg::zone_t                       sample_zone;
  hld_pkg::zone_t                       zone_next;
  hld_pkg::zone_t                       latched_zone_next;
  logic                                 is_stable_next;
  hld_pkg::time_t                       zone_start_time_next;
  hld_pkg::time_t                       elapsed;
  hld_pkg::time_t                       need;
  logic                                 zone_changed;
  logic                                 fire;
  logic                                 active_next;
  logic                                 advance;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      thresholds   <= '0;
      off_delay    <= '0;
      on_delay     <= '0;
      active_sense <= hld_pkg::SENSE_HIGH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hld_pkg::REG_THRESHOLD_A:  thresholds.a <= cfg_data[hld_pkg::SAMPLE_WIDTH-1:0];
        hld_pkg::REG_THRESHOLD_B:  thresholds.b <= cfg_data[hld_pkg::SAMPLE_WIDTH-1:0];
        hld_pkg::REG_OFF_DELAY:    off_delay    <= cfg_data[hld_pkg::TIME_WIDTH-1:0];
        hld_pkg::REG_ON_DELAY:     on_delay     <= cfg_data[hld_pkg::TIME_WIDTH-1:0];
        hld_pkg::REG_ACTIVE_SENSE: active_sense <= cfg_data[hld_pkg::SENSE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register into the result register whenever the result
  // slot is empty or being taken this cycle.
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_sample    <= sample;
      s1_timestamp <= timestamp;
    end
  end

  hld_classify u_classify (
    .thresholds (thresholds),
    .sample     (s1_sample),
    .zone       (sample_zone)
  );

  // Zone update. A fresh zone starts its timer at this timestamp, so its
  // elapsed time is zero and only a zero delay latches it straight away.
  assign zone_changed = (sample_zone != hld_pkg::ZONE_BETWEEN) && (sample_zone != zone);
  assign elapsed      = s1_timestamp - zone_start_time;
  assign need         = (sample_zone == hld_pkg::ZONE_HIGH) ? on_delay : off_delay;

  always_comb begin
    zone_next            = zone;
    zone_start_time_next = zone_start_time;
    is_stable_next       = is_stable;
    fire                 = 1'b0;
    priority if (sample_zone == hld_pkg::ZONE_BETWEEN) begin
      // Drop stability but keep the tracked zone and its start time.
      is_stable_next = 1'b0;
    end else if (zone_changed) begin
      zone_next            = sample_zone;
      zone_start_time_next = s1_timestamp;
      fire                 = (need == '0);
      is_stable_next       = fire;
    end else begin
      fire           = !is_stable && (elapsed >= need);
      is_stable_next = is_stable || fire;
    end
  end

  assign latched_zone_next = fire ? sample_zone : latched_zone;

  always_comb begin
    unique case (active_sense)
      hld_pkg::SENSE_HIGH: active_next = (latched_zone_next == hld_pkg::ZONE_HIGH);
      hld_pkg::SENSE_LOW:  active_next = (latched_zone_next == hld_pkg::ZONE_LOW);
      default:             active_next = 1'b0;
    endcase
  end

  // State register moves only on advance; result_valid also clears when not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone            <= hld_pkg::ZONE_BETWEEN;
      latched_zone    <= hld_pkg::ZONE_BETWEEN;
      is_stable       <= 1'b0;
      zone_start_time <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (advance) begin
        zone            <= zone_next;
        latched_zone    <= latched_zone_next;
        is_stable       <= is_stable_next;
        zone_start_time <= zone_start_time_next;
        result_valid    <= 1'b1;
      end else if (!result_stall) begin
        result_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      latched_now  <= fire;
      active       <= active_next;
      tracked_zone <= zone_next;
    end
  end

  // Checks
  `HLD_ASSERT_IMPL(a_stable_matches_latch, clk, rst, is_stable,
                   (zone == latched_zone) && (zone != hld_pkg::ZONE_BETWEEN))
  `HLD_ASSERT_IMPL(a_latch_has_zone, clk, rst, result_valid && latched_now,
                   tracked_zone != hld_pkg::ZONE_BETWEEN)
  `HLD_ASSERT_NEXT(a_state_holds, clk, rst, !advance,
                   $stable(zone) && $stable(is_stable) && $stable(latched_zone))
  `HLD_ASSERT_NEXT(a_start_time_on_change, clk, rst, advance && zone_changed,
                   zone_start_time == $past(s1_timestamp))

endmodule
